// ===== hdl/i2cseq_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Shared types and constants of the I2C sensor measurement sequencer: bus
// timing, register indexes, status codes, sequencer phases and the result
// bundle passed between the sequencer and the temperature converter.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

	// Bus timing in ticks
	localparam int BIT_PHASE_TICKS  = 2;
	localparam int START_HOLD_TICKS = 5;
	localparam int READ_BYTES       = 6;

	localparam int TICK_W = 20;

	// Tick thresholds used by the sequencer
	localparam logic [TICK_W-1:0] T_B        = TICK_W'(BIT_PHASE_TICKS);
	localparam logic [TICK_W-1:0] T_B_M1     = TICK_W'(BIT_PHASE_TICKS - 1);
	localparam logic [TICK_W-1:0] T_2B       = TICK_W'(2 * BIT_PHASE_TICKS);
	localparam logic [TICK_W-1:0] T_2B_M1    = TICK_W'(2 * BIT_PHASE_TICKS - 1);
	localparam logic [TICK_W-1:0] T_3B_M1    = TICK_W'(3 * BIT_PHASE_TICKS - 1);
	localparam logic [TICK_W-1:0] T_H        = TICK_W'(START_HOLD_TICKS);
	localparam logic [TICK_W-1:0] T_2H_M1    = TICK_W'(2 * START_HOLD_TICKS - 1);
	localparam logic [TICK_W-1:0] T_BH       = TICK_W'(BIT_PHASE_TICKS + START_HOLD_TICKS);
	localparam logic [TICK_W-1:0] T_2BH_M1   =
		TICK_W'(2 * BIT_PHASE_TICKS + START_HOLD_TICKS - 1);

	localparam logic [2:0] BIT_LAST  = 3'd7;
	localparam logic [2:0] BYTE_LAST = 3'(READ_BYTES - 1);

	// Configuration register file
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEVICE_ADDRESS  = 4'd0,
		REG_MEASURE_COMMAND = 4'd1,
		REG_WAIT_TICKS      = 4'd2,
		REG_FAHRENHEIT_MODE = 4'd3
	} reg_idx_t;

	localparam logic [6:0]        RST_DEVICE_ADDRESS  = 7'd68;
	localparam logic [7:0]        RST_MEASURE_COMMAND = 8'd253;
	localparam logic [TICK_W-1:0] RST_WAIT_TICKS      = 20'd18000;

	typedef struct packed {
		logic [6:0]        device_address;
		logic [7:0]        measure_command;
		logic [TICK_W-1:0] wait_ticks;
		logic              fahrenheit_mode;
	} cfg_t;

	// Sequence status codes
	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_ADDRW_NACK = 2'd1,
		STATUS_CMD_NACK   = 2'd2,
		STATUS_ADDRR_NACK = 2'd3
	} status_t;

	// Sequencer phases, one-hot
	typedef enum logic [13:0] {
		PH_IDLE    = 14'b00000000000001,
		PH_START1  = 14'b00000000000010,
		PH_ADDRW   = 14'b00000000000100,
		PH_ACK1    = 14'b00000000001000,
		PH_CMD     = 14'b00000000010000,
		PH_ACK2    = 14'b00000000100000,
		PH_STOPMID = 14'b00000001000000,
		PH_WAIT    = 14'b00000010000000,
		PH_START2  = 14'b00000100000000,
		PH_ADDRR   = 14'b00001000000000,
		PH_ACK3    = 14'b00010000000000,
		PH_READ    = 14'b00100000000000,
		PH_RACK    = 14'b01000000000000,
		PH_STOPEND = 14'b10000000000000
	} phase_t;

	// Temperature scaling: floor(raw * K / 65535) - offset
	localparam logic [14:0] TEMP_K_C   = 15'd17500;
	localparam logic [14:0] TEMP_K_F   = 15'd31500;
	localparam logic [15:0] TEMP_OFF_C = 16'd4500;
	localparam logic [15:0] TEMP_OFF_F = 16'd4900;

	// One tick's result, before temperature conversion
	typedef struct packed {
		logic        scl_level;
		logic        sda_drive;
		logic        sda_level;
		logic        busy_res;
		logic        done_res;
		status_t     status;
		logic [15:0] temperature_raw;
		logic [15:0] humidity_raw;
		logic        fahrenheit;
	} res_t;

endpackage

// ===== hdl/i2cseq_in_if.sv =====
// ----------------------------------------------------------------------------
// i2cseq_in_if
// Tick channel into the sequencer: start request and sampled SDA level.
// ----------------------------------------------------------------------------
interface i2cseq_in_if;
	logic valid;
	logic ready;
	logic start_request;
	logic sda_sample;

	modport source (output valid, output start_request, output sda_sample, input ready);
	modport sink (input valid, input start_request, input sda_sample, output ready);
endinterface

// ===== hdl/i2cseq_out_if.sv =====
// ----------------------------------------------------------------------------
// i2cseq_out_if
// Per-tick result channel: bus levels, sequence status and sensor readings.
// ----------------------------------------------------------------------------
interface i2cseq_out_if;
	logic               valid;
	logic               ready;
	logic               scl_level;
	logic               sda_drive;
	logic               sda_level;
	logic               busy_res;
	logic               done_res;
	logic [1:0]         status;
	logic [15:0]        temperature_raw;
	logic [15:0]        humidity_raw;
	logic signed [15:0] temperature_hundredths;

	modport source (
		output valid, output scl_level, output sda_drive, output sda_level,
		output busy_res, output done_res, output status, output temperature_raw,
		output humidity_raw, output temperature_hundredths, input ready
	);
	modport sink (
		input valid, input scl_level, input sda_drive, input sda_level,
		input busy_res, input done_res, input status, input temperature_raw,
		input humidity_raw, input temperature_hundredths, output ready
	);
endinterface

// ===== hdl/i2cseq_cfg_if.sv =====
// ----------------------------------------------------------------------------
// i2cseq_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface i2cseq_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [i2cseq_pkg::CFG_IDX_W-1:0]  index;
	logic [i2cseq_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/i2c_sensor_measure_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_sensor_measure_sequencer
// I2C master that runs a measure-and-read sequence on a temperature and
// humidity sensor, one bus tick per input transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one bus tick and yields exactly one result
// transaction carrying that tick's SCL/SDA levels, busy/done flags, status
// and the latest readings. The block takes one tick per clock cycle while
// the result side keeps ready high; each result passes three registers
// (sequencer stage register, multiplier stage, output register) on its way
// to the output, and a stage stalls when it is full and the stage after it
// cannot take its result. Temperature in hundredths
// is computed from the raw reading with one constant multiply and a
// shift-and-correct divide by 65535. Configuration writes are taken every
// cycle and should only be issued while no sequence is running.
// ----------------------------------------------------------------------------
module i2c_sensor_measure_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	i2cseq_in_if.sink     in_ch,
	i2cseq_out_if.source  out_ch,
	i2cseq_cfg_if.sink    cfg_ch
);

	i2cseq_pkg::cfg_t cfg;
	logic             valid_s1;
	i2cseq_pkg::res_t res_s1;
	logic             ready_s2;

	i2cseq_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	i2cseq_bus_fsm u_bus_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.res_s1   (res_s1),
		.ready_s2 (ready_s2)
	);

	i2cseq_temp_conv u_temp_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res_s1   (res_s1),
		.ready_s2 (ready_s2),
		.out_ch   (out_ch)
	);

`ifndef SYNTHESIS
	// Done only ends a running sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.done_res |-> out_ch.busy_res)
		else $error("done without busy");

	// Idle bus: SCL high, SDA released
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.busy_res |-> out_ch.scl_level && !out_ch.sda_drive)
		else $error("bus driven while idle");

	// Released SDA reports level zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.sda_drive |-> !out_ch.sda_level)
		else $error("sda level set while released");

	// Converted temperature stays within the scale range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.temperature_hundredths >= -16'sd4900 &&
			out_ch.temperature_hundredths <= 16'sd26600)
		else $error("temperature out of range");
`endif

endmodule

// ===== hdl/i2cseq_cfg.sv =====
// ----------------------------------------------------------------------------
// i2cseq_cfg
// Configuration register file. Takes one write per cycle; writes to an
// index outside the register list are accepted and dropped.
// ----------------------------------------------------------------------------
module i2cseq_cfg (
	input  logic                clk,
	input  logic                arst_n,
	i2cseq_cfg_if.sink          cfg_ch,
	output i2cseq_pkg::cfg_t    cfg
);

	i2cseq_pkg::cfg_t cfg_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg = cfg_q;

	// Update the addressed register on each write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address  <= i2cseq_pkg::RST_DEVICE_ADDRESS;
			cfg_q.measure_command <= i2cseq_pkg::RST_MEASURE_COMMAND;
			cfg_q.wait_ticks      <= i2cseq_pkg::RST_WAIT_TICKS;
			cfg_q.fahrenheit_mode <= 1'b0;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				i2cseq_pkg::REG_DEVICE_ADDRESS: begin
					cfg_q.device_address <= cfg_ch.data[6:0];
				end
				i2cseq_pkg::REG_MEASURE_COMMAND: begin
					cfg_q.measure_command <= cfg_ch.data[7:0];
				end
				i2cseq_pkg::REG_WAIT_TICKS: begin
					cfg_q.wait_ticks <= cfg_ch.data[i2cseq_pkg::TICK_W-1:0];
				end
				i2cseq_pkg::REG_FAHRENHEIT_MODE: begin
					cfg_q.fahrenheit_mode <= cfg_ch.data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hdl/i2cseq_bus_fsm.sv =====
// ----------------------------------------------------------------------------
// i2cseq_bus_fsm
// Bit-level I2C master sequencer. Each accepted tick advances the phase,
// tick, bit and byte counters and produces that tick's bus levels, status
// and raw readings into a stage register.
// ----------------------------------------------------------------------------
module i2cseq_bus_fsm (
	input  logic               clk,
	input  logic               arst_n,
	i2cseq_in_if.sink          in_ch,
	input  i2cseq_pkg::cfg_t   cfg,
	output logic               valid_s1,
	output i2cseq_pkg::res_t   res_s1,
	input  logic               ready_s2
);

	localparam int TW = i2cseq_pkg::TICK_W;

	i2cseq_pkg::phase_t  phase_q;
	logic [TW-1:0]       tick_q;
	logic [2:0]          bit_q;
	logic [2:0]          byte_q;
	logic [7:0]          shift_q;
	logic                ack_q;
	i2cseq_pkg::status_t status_q;
	logic [15:0]         traw_q;
	logic [15:0]         hraw_q;

	i2cseq_pkg::phase_t  ph;
	i2cseq_pkg::phase_t  ph_n;
	i2cseq_pkg::phase_t  go_ph;
	logic [TW-1:0]       t;
	logic [TW:0]         t_inc;
	logic [2:0]          bc;
	logic [2:0]          byc;
	logic [7:0]          sh;
	logic                ack;
	i2cseq_pkg::status_t st;
	logic [15:0]         traw;
	logic [15:0]         hraw;
	logic                scl;
	logic                drv;
	logic                lvl;
	logic                busy;
	logic                done;
	logic                last;
	logic                go;
	logic                step;
	logic                ready_s1;

	assign ready_s1    = !valid_s1 || ready_s2;
	assign in_ch.ready = ready_s1;
	assign step        = in_ch.valid && ready_s1;

	// Compute one tick: outputs and next sequencer state
	always_comb begin
		ph    = phase_q;
		t     = tick_q;
		bc    = bit_q;
		byc   = byte_q;
		sh    = shift_q;
		ack   = ack_q;
		st    = status_q;
		traw  = traw_q;
		hraw  = hraw_q;
		scl   = 1'b1;
		drv   = 1'b0;
		lvl   = 1'b0;
		done  = 1'b0;
		last  = 1'b0;
		go    = 1'b0;
		go_ph = i2cseq_pkg::PH_IDLE;

		// A start request while idle is the first tick of the start condition
		if (ph == i2cseq_pkg::PH_IDLE && in_ch.start_request) begin
			st  = i2cseq_pkg::STATUS_OK;
			byc = '0;
			ph  = i2cseq_pkg::PH_START1;
			t   = '0;
			bc  = '0;
			ack = 1'b0;
		end
		busy  = (ph != i2cseq_pkg::PH_IDLE);
		ph_n  = ph;
		t_inc = {1'b0, t} + (TW+1)'(1);

		// Drive bus levels for this tick
		unique case (ph)
			i2cseq_pkg::PH_START1, i2cseq_pkg::PH_START2: begin
				drv  = 1'b1;
				lvl  = (t < i2cseq_pkg::T_H);
				last = (t >= i2cseq_pkg::T_2H_M1);
			end
			i2cseq_pkg::PH_ADDRW, i2cseq_pkg::PH_CMD, i2cseq_pkg::PH_ADDRR: begin
				drv  = 1'b1;
				lvl  = sh[7];
				scl  = (t >= i2cseq_pkg::T_B) && (t < i2cseq_pkg::T_2B);
				last = (t >= i2cseq_pkg::T_3B_M1);
			end
			i2cseq_pkg::PH_ACK1, i2cseq_pkg::PH_ACK2, i2cseq_pkg::PH_ACK3: begin
				scl = (t < i2cseq_pkg::T_2B);
				if (t < i2cseq_pkg::T_2B && !in_ch.sda_sample) begin
					ack = 1'b1;
				end
				last = (t >= i2cseq_pkg::T_2BH_M1);
			end
			i2cseq_pkg::PH_STOPMID, i2cseq_pkg::PH_STOPEND: begin
				drv  = 1'b1;
				lvl  = (t >= i2cseq_pkg::T_BH);
				scl  = (t >= i2cseq_pkg::T_B);
				last = (t >= i2cseq_pkg::T_2BH_M1);
			end
			i2cseq_pkg::PH_WAIT: begin
				last = (t_inc >= {1'b0, cfg.wait_ticks});
			end
			i2cseq_pkg::PH_READ: begin
				scl = (t < i2cseq_pkg::T_B);
				if (t == i2cseq_pkg::T_B_M1) begin
					sh = {sh[6:0], in_ch.sda_sample};
				end
				last = (t >= i2cseq_pkg::T_2B_M1);
			end
			i2cseq_pkg::PH_RACK: begin
				drv  = 1'b1;
				lvl  = (byc >= i2cseq_pkg::BYTE_LAST);
				scl  = (t < i2cseq_pkg::T_B);
				last = (t >= i2cseq_pkg::T_2B_M1);
			end
			default: begin
			end
		endcase

		// Advance the tick counter or move to the next phase
		if (ph != i2cseq_pkg::PH_IDLE) begin
			if (!last) begin
				t = t_inc[TW-1:0];
			end else begin
				unique case (ph)
					i2cseq_pkg::PH_START1: begin
						go    = 1'b1;
						go_ph = i2cseq_pkg::PH_ADDRW;
					end
					i2cseq_pkg::PH_START2: begin
						go    = 1'b1;
						go_ph = i2cseq_pkg::PH_ADDRR;
					end
					i2cseq_pkg::PH_ADDRW, i2cseq_pkg::PH_CMD, i2cseq_pkg::PH_ADDRR: begin
						sh = {sh[6:0], 1'b0};
						t  = '0;
						if (bc == i2cseq_pkg::BIT_LAST) begin
							go = 1'b1;
							if (ph == i2cseq_pkg::PH_ADDRW) begin
								go_ph = i2cseq_pkg::PH_ACK1;
							end else if (ph == i2cseq_pkg::PH_CMD) begin
								go_ph = i2cseq_pkg::PH_ACK2;
							end else begin
								go_ph = i2cseq_pkg::PH_ACK3;
							end
						end else begin
							bc = bc + 3'd1;
						end
					end
					i2cseq_pkg::PH_ACK1: begin
						go = 1'b1;
						if (ack) begin
							go_ph = i2cseq_pkg::PH_CMD;
						end else begin
							st    = i2cseq_pkg::STATUS_ADDRW_NACK;
							go_ph = i2cseq_pkg::PH_STOPEND;
						end
					end
					i2cseq_pkg::PH_ACK2: begin
						go = 1'b1;
						if (ack) begin
							go_ph = i2cseq_pkg::PH_STOPMID;
						end else begin
							st    = i2cseq_pkg::STATUS_CMD_NACK;
							go_ph = i2cseq_pkg::PH_STOPEND;
						end
					end
					i2cseq_pkg::PH_ACK3: begin
						go = 1'b1;
						if (ack) begin
							go_ph = i2cseq_pkg::PH_READ;
						end else begin
							st    = i2cseq_pkg::STATUS_ADDRR_NACK;
							go_ph = i2cseq_pkg::PH_STOPEND;
						end
					end
					i2cseq_pkg::PH_STOPMID: begin
						go    = 1'b1;
						go_ph = i2cseq_pkg::PH_WAIT;
					end
					i2cseq_pkg::PH_WAIT: begin
						go    = 1'b1;
						go_ph = i2cseq_pkg::PH_START2;
					end
					i2cseq_pkg::PH_READ: begin
						t = '0;
						if (bc == i2cseq_pkg::BIT_LAST) begin
							// Store the completed byte where the readings use it
							unique case (byc)
								3'd0: traw[15:8] = sh;
								3'd1: traw[7:0]  = sh;
								3'd3: hraw[15:8] = sh;
								3'd4: hraw[7:0]  = sh;
								default: begin
								end
							endcase
							go    = 1'b1;
							go_ph = i2cseq_pkg::PH_RACK;
						end else begin
							bc = bc + 3'd1;
						end
					end
					i2cseq_pkg::PH_RACK: begin
						go = 1'b1;
						if (byc >= i2cseq_pkg::BYTE_LAST) begin
							go_ph = i2cseq_pkg::PH_STOPEND;
						end else begin
							byc   = byc + 3'd1;
							go_ph = i2cseq_pkg::PH_READ;
						end
					end
					i2cseq_pkg::PH_STOPEND: begin
						done = 1'b1;
						ph_n = i2cseq_pkg::PH_IDLE;
						t    = '0;
						bc   = '0;
					end
					default: begin
						ph_n = i2cseq_pkg::PH_IDLE;
					end
				endcase
			end
		end

		// Enter the new phase: clear counters and load the shift register
		if (go) begin
			if (go_ph == i2cseq_pkg::PH_WAIT && cfg.wait_ticks == '0) begin
				ph_n = i2cseq_pkg::PH_START2;
			end else begin
				ph_n = go_ph;
			end
			t   = '0;
			bc  = '0;
			ack = 1'b0;
			unique case (ph_n)
				i2cseq_pkg::PH_ADDRW: sh = {cfg.device_address, 1'b0};
				i2cseq_pkg::PH_CMD:   sh = cfg.measure_command;
				i2cseq_pkg::PH_ADDRR: sh = {cfg.device_address, 1'b1};
				i2cseq_pkg::PH_READ:  sh = '0;
				default: begin
				end
			endcase
		end
	end

	// Hold sequencer state, advance it on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= i2cseq_pkg::PH_IDLE;
			tick_q   <= '0;
			bit_q    <= '0;
			byte_q   <= '0;
			shift_q  <= '0;
			ack_q    <= 1'b0;
			status_q <= i2cseq_pkg::STATUS_OK;
			traw_q   <= '0;
			hraw_q   <= '0;
		end else if (step) begin
			phase_q  <= ph_n;
			tick_q   <= t;
			bit_q    <= bc;
			byte_q   <= byc;
			shift_q  <= sh;
			ack_q    <= ack;
			status_q <= st;
			traw_q   <= traw;
			hraw_q   <= hraw;
		end
	end

	// Stage register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Stage register payload
	always_ff @(posedge clk) begin
		if (step) begin
			res_s1.scl_level       <= scl;
			res_s1.sda_drive       <= drv;
			res_s1.sda_level       <= drv & lvl;
			res_s1.busy_res        <= busy;
			res_s1.done_res        <= done;
			res_s1.status          <= st;
			res_s1.temperature_raw <= traw;
			res_s1.humidity_raw    <= hraw;
			res_s1.fahrenheit      <= cfg.fahrenheit_mode;
		end
	end

endmodule

// ===== hdl/i2cseq_temp_conv.sv =====
// ----------------------------------------------------------------------------
// i2cseq_temp_conv
// Temperature conversion in two stages: scale the raw reading by a
// constant, then divide by 65535 with a shift-and-correct and subtract the
// scale offset into the output register.
// ----------------------------------------------------------------------------
module i2cseq_temp_conv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  i2cseq_pkg::res_t   res_s1,
	output logic               ready_s2,
	i2cseq_out_if.source       out_ch
);

	logic               valid_s2;
	i2cseq_pkg::res_t   res_s2;
	logic [30:0]        prod_s2;
	logic [15:0]        off_s2;
	logic               valid_q;
	logic               ready_q;
	logic [31:0]        corr_sum;
	logic [15:0]        quot;
	logic               take_s1;
	logic               take_s2;

	assign ready_q  = !valid_q || out_ch.ready;
	assign ready_s2 = !valid_s2 || ready_q;
	assign take_s1  = valid_s1 && ready_s2;
	assign take_s2  = valid_s2 && ready_q;

	// x / 65535 for x below 2^31: (x + (x >> 16) + 1) >> 16
	assign corr_sum = 32'(prod_s2) + 32'(prod_s2[30:16]) + 32'd1;
	assign quot     = corr_sum[31:16];

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_q) begin
				valid_q <= valid_s2;
			end
		end
	end

	// Scale the raw temperature
	always_ff @(posedge clk) begin
		if (take_s1) begin
			res_s2  <= res_s1;
			prod_s2 <= 31'(res_s1.temperature_raw) *
				31'(res_s1.fahrenheit ? i2cseq_pkg::TEMP_K_F : i2cseq_pkg::TEMP_K_C);
			off_s2  <= res_s1.fahrenheit ? i2cseq_pkg::TEMP_OFF_F : i2cseq_pkg::TEMP_OFF_C;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (take_s2) begin
			out_ch.scl_level              <= res_s2.scl_level;
			out_ch.sda_drive              <= res_s2.sda_drive;
			out_ch.sda_level              <= res_s2.sda_level;
			out_ch.busy_res               <= res_s2.busy_res;
			out_ch.done_res               <= res_s2.done_res;
			out_ch.status                 <= res_s2.status;
			out_ch.temperature_raw        <= res_s2.temperature_raw;
			out_ch.humidity_raw           <= res_s2.humidity_raw;
			out_ch.temperature_hundredths <= $signed(quot - off_s2);
		end
	end

	assign out_ch.valid = valid_q;

endmodule
